@@ hdl/line_edit_buffer_assert.svh @@
// Assertion macros for the line edit buffer.
`ifndef LINE_EDIT_BUFFER_ASSERT_SVH
`define LINE_EDIT_BUFFER_ASSERT_SVH

// check a consequence in the same cycle
`define LEB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line edit buffer check failed");

// check a consequence in the next cycle
`define LEB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line edit buffer check failed");

`endif

@@ hdl/leb_pkg.sv @@
// Shared types and codes for the line edit buffer.
package leb_pkg;

   localparam logic [3:0] ACT_INSERT    = 4'd0;
   localparam logic [3:0] ACT_BACKSPACE = 4'd1;
   localparam logic [3:0] ACT_DELETE    = 4'd2;
   localparam logic [3:0] ACT_LEFT      = 4'd3;
   localparam logic [3:0] ACT_RIGHT     = 4'd4;
   localparam logic [3:0] ACT_HOME      = 4'd5;
   localparam logic [3:0] ACT_END       = 4'd6;
   localparam logic [3:0] ACT_CLEAR     = 4'd7;
   localparam logic [3:0] ACT_READ      = 4'd8;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] char_in;
      logic [5:0] read_index;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] count;
      logic [7:0] char_out;
      logic [5:0] length;
      logic [5:0] cursor;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SHIFT,
      ST_PUT_CHAR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch;
      logic start_shift;
      logic step_shift;
      logic put_char;
      logic issue_read;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_shift;
      logic is_read;
      logic is_insert;
      logic shift_busy;
      logic rsp_free;
   } dp_status_type;

endpackage

@@ hdl/leb_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/leb_ctrl.sv @@
// Controller state machine for the line edit buffer.
module leb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  leb_pkg::dp_status_type status,
   output leb_pkg::dp_cmd_type    cmd
);

   leb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= leb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         leb_pkg::ST_IDLE: begin
            if (req_valid) state_in = leb_pkg::ST_EXEC;
         end
         leb_pkg::ST_EXEC: begin
            state_in = status.needs_shift ? leb_pkg::ST_SHIFT : leb_pkg::ST_FINISH;
         end
         leb_pkg::ST_SHIFT: begin
            if (!status.shift_busy) begin
               state_in = status.is_insert ? leb_pkg::ST_PUT_CHAR : leb_pkg::ST_FINISH;
            end
         end
         leb_pkg::ST_PUT_CHAR: begin
            state_in = leb_pkg::ST_FINISH;
         end
         leb_pkg::ST_FINISH: begin
            if (status.rsp_free) state_in = leb_pkg::ST_IDLE;
         end
         default: state_in = leb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         leb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         leb_pkg::ST_EXEC: begin
            cmd.start_shift = status.needs_shift;
            cmd.issue_read  = status.is_read;
         end
         leb_pkg::ST_SHIFT: begin
            cmd.step_shift = 1'b1;
         end
         leb_pkg::ST_PUT_CHAR: begin
            cmd.put_char = 1'b1;
         end
         leb_pkg::ST_FINISH: begin
            cmd.commit = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ hdl/leb_datapath.sv @@
// Datapath for the line edit buffer: line store, length, cursor, shifter, result word.
`include "line_edit_buffer_assert.svh"

module leb_datapath #(
   parameter int LINE_SIZE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  leb_pkg::req_type       req_data,
   input  leb_pkg::dp_cmd_type    cmd,
   output leb_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output leb_pkg::rsp_type       rsp_data
);

   localparam int LW = $clog2(LINE_SIZE);
   localparam int CW = (LW > 6) ? LW : 6;

   leb_pkg::req_type req_ff;
   logic [LW-1:0]    length_ff, cursor_ff;
   logic [LW-1:0]    src_ff, remain_ff, pend_addr_ff;
   logic             pend_ff;
   leb_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   logic          is_insert, is_bs, is_del, is_read;
   logic          full, cur_nz, cur_lt, read_in_range, rsp_free;
   logic [LW-1:0] src_start, remain_start, dst;
   logic [LW-1:0] new_len, new_cur, count_w;
   logic          ok_w;

   logic          ram_wr_en, ram_rd_en;
   logic [LW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   assign is_insert     = req_ff.action == leb_pkg::ACT_INSERT;
   assign is_bs         = req_ff.action == leb_pkg::ACT_BACKSPACE;
   assign is_del        = req_ff.action == leb_pkg::ACT_DELETE;
   assign is_read       = req_ff.action == leb_pkg::ACT_READ;
   assign full          = length_ff >= LW'(LINE_SIZE - 1);
   assign cur_nz        = cursor_ff != '0;
   assign cur_lt        = cursor_ff < length_ff;
   assign read_in_range = CW'(req_ff.read_index) < CW'(length_ff);
   assign rsp_free      = !rsp_valid_ff || rsp_ready;

   assign status.needs_shift = (is_insert && !full) || (is_bs && cur_nz) || (is_del && cur_lt);
   assign status.is_read     = is_read;
   assign status.is_insert   = is_insert;
   assign status.shift_busy  = (remain_ff != '0) || pend_ff;
   assign status.rsp_free    = rsp_free;

   assign src_start    = is_insert ? (length_ff - LW'(1)) :
                         (is_bs ? cursor_ff : (cursor_ff + LW'(1)));
   assign remain_start = is_del ? (length_ff - cursor_ff - LW'(1)) : (length_ff - cursor_ff);
   assign dst          = is_insert ? (src_ff + LW'(1)) : (src_ff - LW'(1));

   assign ram_rd_en   = (cmd.step_shift && (remain_ff != '0)) || cmd.issue_read;
   assign ram_rd_addr = cmd.issue_read ? LW'(req_ff.read_index) : src_ff;
   assign ram_wr_en   = (cmd.step_shift && pend_ff) || cmd.put_char;
   assign ram_wr_addr = cmd.put_char ? cursor_ff : pend_addr_ff;
   assign ram_wr_data = cmd.put_char ? req_ff.char_in : ram_rd_data;

   leb_ram #(
      .WIDTH (8),
      .DEPTH (LINE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      new_len = length_ff;
      new_cur = cursor_ff;
      count_w = '0;
      ok_w    = 1'b0;
      unique case (req_ff.action)
         leb_pkg::ACT_INSERT: begin
            ok_w = !full;
            if (!full) begin
               new_len = length_ff + LW'(1);
               new_cur = cursor_ff + LW'(1);
            end
         end
         leb_pkg::ACT_BACKSPACE: begin
            ok_w = cur_nz;
            if (cur_nz) begin
               new_len = length_ff - LW'(1);
               new_cur = cursor_ff - LW'(1);
            end
         end
         leb_pkg::ACT_DELETE: begin
            ok_w = cur_lt;
            if (cur_lt) begin
               new_len = length_ff - LW'(1);
               count_w = length_ff - LW'(1) - cursor_ff;
            end
         end
         leb_pkg::ACT_LEFT: begin
            ok_w = cur_nz;
            if (cur_nz) new_cur = cursor_ff - LW'(1);
         end
         leb_pkg::ACT_RIGHT: begin
            ok_w = cur_lt;
            if (cur_lt) new_cur = cursor_ff + LW'(1);
         end
         leb_pkg::ACT_HOME: begin
            ok_w    = 1'b1;
            count_w = cursor_ff;
            new_cur = '0;
         end
         leb_pkg::ACT_END: begin
            ok_w    = 1'b1;
            count_w = length_ff - cursor_ff;
            new_cur = length_ff;
         end
         leb_pkg::ACT_CLEAR: begin
            ok_w    = 1'b1;
            new_len = '0;
            new_cur = '0;
         end
         leb_pkg::ACT_READ: begin
            ok_w = read_in_range;
         end
         default: begin
            ok_w = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_in.ok       = ok_w;
      rsp_in.count    = 6'(count_w);
      rsp_in.char_out = (is_read && read_in_range) ? ram_rd_data : 8'd0;
      rsp_in.length   = 6'(new_len);
      rsp_in.cursor   = 6'(new_cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         cursor_ff    <= '0;
         remain_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start_shift) begin
            remain_ff <= remain_start;
            pend_ff   <= 1'b0;
         end else if (cmd.step_shift) begin
            if (remain_ff != '0) begin
               remain_ff <= remain_ff - LW'(1);
               pend_ff   <= 1'b1;
            end else begin
               pend_ff <= 1'b0;
            end
         end
         if (cmd.commit) begin
            length_ff    <= new_len;
            cursor_ff    <= new_cur;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.start_shift) begin
         src_ff <= src_start;
      end else if (cmd.step_shift && (remain_ff != '0)) begin
         src_ff       <= is_insert ? (src_ff - LW'(1)) : (src_ff + LW'(1));
         pend_addr_ff <= dst;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LEB_ASSERT_IMPL(a_cursor_in_line, 1'b1, cursor_ff <= length_ff)
   `LEB_ASSERT_IMPL(a_no_port_clash, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
   `LEB_ASSERT_IMPL(a_commit_when_free, cmd.commit, rsp_free)
   `LEB_ASSERT_NEXT(a_commit_shows_word, cmd.commit, rsp_valid_ff)

endmodule

@@ hdl/line_edit_buffer.sv @@
// Top level of the line edit buffer: controller plus datapath.
// Moves, home, end, clear, read and refused edits pass through EXEC and FINISH; rsp_valid rises after commit.
// Insert, backspace and delete move n tail positions, one a cycle through the RAM port,
// in the SHIFT state; insert then writes its character in PUT_CHAR before FINISH.
// One word in work: the next request is accepted only after commit, back in IDLE.
// Reset clears length and cursor at once; the store needs no clearing pass.
module line_edit_buffer #(
   parameter int LINE_SIZE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  leb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output leb_pkg::rsp_type rsp_data
);

   leb_pkg::dp_cmd_type    cmd;
   leb_pkg::dp_status_type status;

   leb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   leb_datapath #(
      .LINE_SIZE (LINE_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
